>>> design/soc_pkg.sv
// Shared types, codes and constants for the segment collision checker.
package soc_pkg;

  localparam int unsigned MAX_OBSTACLES_DEF = 64;
  localparam int unsigned COORD_WIDTH_DEF   = 16;
  localparam int unsigned EPS_W             = 30;
  localparam logic [EPS_W-1:0] EPS_RESET    = 30'd671;
  localparam int unsigned REQ_W             = 2;
  localparam int unsigned TAG_IDX_W         = 10;
  localparam int unsigned OUT_IDX_W         = 6;
  localparam int unsigned OUT_CNT_W         = 7;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 valid;
    logic [TAG_IDX_W-1:0] idx;
  } tag_t;

endpackage

>>> design/soc_cell.sv
// One obstacle cell of the rotating table.
module soc_cell #(
  parameter int unsigned EW = 64
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic          load_i,
  input  logic [EW-1:0] load_data_i,
  input  logic [EW-1:0] next_data_i,
  output logic [EW-1:0] data_o
);

  logic [EW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> design/soc_check.sv
// Pipelined intersection test of the query against one obstacle per cycle.
module soc_check #(
  parameter int unsigned CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CW-1:0]        qx0_i,
  input  logic [CW-1:0]        qy0_i,
  input  logic signed [CW:0]   d0x_i,
  input  logic signed [CW:0]   d0y_i,
  input  logic [4*CW-1:0]      obs_i,
  input  soc_pkg::tag_t        tag_i,
  input  logic [soc_pkg::EPS_W-1:0] eps_i,
  output soc_pkg::tag_t        res_o
);

  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned MW = ((SW > soc_pkg::EPS_W) ? SW : soc_pkg::EPS_W) + 1;

  logic [CW-1:0] ox0, oy0, ox1, oy1;
  assign ox0 = obs_i[CW-1:0];
  assign oy0 = obs_i[2*CW-1:CW];
  assign ox1 = obs_i[3*CW-1:2*CW];
  assign oy1 = obs_i[4*CW-1:3*CW];

  logic signed [DW-1:0] d1x_q, d1y_q, rx_q, ry_q;
  soc_pkg::tag_t        tag_a_q, tag_b_q, tag_c_q;
  logic signed [PW-1:0] p_a_q, p_b_q, p_c_q, p_d_q, p_e_q, p_f_q;
  logic signed [SW-1:0] det_q, snum_q, tnum_q;

  always_ff @(posedge clk_i) begin
    d1x_q <= $signed({ox1[CW-1], ox1}) - $signed({ox0[CW-1], ox0});
    d1y_q <= $signed({oy1[CW-1], oy1}) - $signed({oy0[CW-1], oy0});
    rx_q  <= $signed({ox0[CW-1], ox0}) - $signed({qx0_i[CW-1], qx0_i});
    ry_q  <= $signed({oy0[CW-1], oy0}) - $signed({qy0_i[CW-1], qy0_i});
    p_a_q <= PW'(d0x_i) * PW'(d1y_q);
    p_b_q <= PW'(d0y_i) * PW'(d1x_q);
    p_c_q <= PW'(rx_q) * PW'(d1y_q);
    p_d_q <= PW'(ry_q) * PW'(d1x_q);
    p_e_q <= PW'(rx_q) * PW'(d0y_i);
    p_f_q <= PW'(ry_q) * PW'(d0x_i);
    det_q  <= SW'(p_a_q) - SW'(p_b_q);
    snum_q <= SW'(p_c_q) - SW'(p_d_q);
    tnum_q <= SW'(p_e_q) - SW'(p_f_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  logic signed [SW-1:0] mag;
  logic                 big, s_ok, t_ok;

  always_comb begin
    mag = det_q[SW-1] ? -det_q : det_q;
    big = MW'(unsigned'(mag)) > MW'(eps_i);
    if (!det_q[SW-1]) begin
      s_ok = !snum_q[SW-1] && (snum_q <= det_q);
      t_ok = !tnum_q[SW-1] && (tnum_q <= det_q);
    end else begin
      s_ok = (snum_q <= 0) && (snum_q >= det_q);
      t_ok = (tnum_q <= 0) && (tnum_q >= det_q);
    end
    res_o.valid = tag_c_q.valid && big && s_ok && t_ok;
    res_o.idx   = tag_c_q.idx;
  end

endmodule

>>> design/segment_obstacle_collision_check.sv
// Top level of the segment collision checker: obstacle ring, test unit and control.
// A clear or append word gives its result in the cycle after acceptance.
// A query word rotates the ring of obstacle cells once through the single intersection
// unit, then its three pipeline stages drain.
// A new word is taken once the previous one has finished and the output register is free.
// Reset empties the table at once and sets the epsilon register to 671; no clearing pass.
module segment_obstacle_collision_check #(
  parameter int unsigned MAX_OBSTACLES = soc_pkg::MAX_OBSTACLES_DEF,
  parameter int unsigned COORD_WIDTH   = soc_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        det_epsilon_we_i,
  input  logic [soc_pkg::EPS_W-1:0]   det_epsilon_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [soc_pkg::REQ_W-1:0]   req_type_i,
  input  logic [COORD_WIDTH-1:0]      seg_x0_i,
  input  logic [COORD_WIDTH-1:0]      seg_y0_i,
  input  logic [COORD_WIDTH-1:0]      seg_x1_i,
  input  logic [COORD_WIDTH-1:0]      seg_y1_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [soc_pkg::OUT_IDX_W-1:0] hit_index_o,
  output logic [soc_pkg::OUT_CNT_W-1:0] obstacle_count_o,
  output logic                        status_o
);

  localparam int unsigned CW   = (COORD_WIDTH > 30) ? 30 : COORD_WIDTH;
  localparam int unsigned EW   = 4 * CW;
  localparam int unsigned IW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_OBSTACLES + 1);

  soc_pkg::state_e state_q, state_d;

  logic [soc_pkg::EPS_W-1:0] eps_q;
  logic [CNTW-1:0]           count_q;
  logic [IW-1:0]             step_q;
  logic [1:0]                drain_q;
  logic                      found_q;
  logic [soc_pkg::TAG_IDX_W-1:0] found_idx_q;
  logic                      out_valid_q, hit_q, status_q;
  logic [soc_pkg::TAG_IDX_W-1:0] idx_q;
  logic [CNTW-1:0]           out_cnt_q;
  logic [CW-1:0]             qx0_q, qy0_q;
  logic signed [CW:0]        d0x_q, d0y_q;

  logic accept, out_free, full, do_append, shift, step_last, load_done;
  logic [EW-1:0] new_seg;
  soc_pkg::tag_t tag, res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == soc_pkg::ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = count_q >= CNTW'(MAX_OBSTACLES);
  assign do_append  = accept && (req_type_i == soc_pkg::REQ_APPEND) && !full;
  assign new_seg    = {seg_y1_i[CW-1:0], seg_x1_i[CW-1:0], seg_y0_i[CW-1:0], seg_x0_i[CW-1:0]};
  assign step_last  = step_q == IW'(MAX_OBSTACLES - 1);

  always_comb begin
    state_d   = state_q;
    shift     = 1'b0;
    load_done = 1'b0;
    case (state_q)
      soc_pkg::ST_IDLE: begin
        if (accept && (req_type_i == soc_pkg::REQ_QUERY)) begin
          state_d = soc_pkg::ST_RUN;
        end
      end
      soc_pkg::ST_RUN: begin
        shift = 1'b1;
        if (step_last) begin
          state_d = soc_pkg::ST_DRAIN;
        end
      end
      soc_pkg::ST_DRAIN: begin
        if (drain_q == 2'd2) begin
          state_d = soc_pkg::ST_DONE;
        end
      end
      soc_pkg::ST_DONE: begin
        if (out_free) begin
          load_done = 1'b1;
          state_d   = soc_pkg::ST_IDLE;
        end
      end
      default: state_d = soc_pkg::ST_IDLE;
    endcase
  end

  assign tag.valid = (state_q == soc_pkg::ST_RUN) && (CNTW'(step_q) < count_q);
  assign tag.idx   = soc_pkg::TAG_IDX_W'(step_q);

  logic [EW-1:0] cell_data [MAX_OBSTACLES];

  for (genvar k = 0; k < MAX_OBSTACLES; k++) begin : g_cell
    soc_cell #(.EW(EW)) u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .load_i      (do_append && (count_q == CNTW'(k))),
      .load_data_i (new_seg),
      .next_data_i (cell_data[(k + 1) % MAX_OBSTACLES]),
      .data_o      (cell_data[k])
    );
  end

  soc_check #(.CW(CW)) u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qx0_i  (qx0_q),
    .qy0_i  (qy0_q),
    .d0x_i  (d0x_q),
    .d0y_i  (d0y_q),
    .obs_i  (cell_data[0]),
    .tag_i  (tag),
    .eps_i  (eps_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx0_q <= seg_x0_i[CW-1:0];
      qy0_q <= seg_y0_i[CW-1:0];
      d0x_q <= $signed({seg_x1_i[CW-1], seg_x1_i[CW-1:0]})
             - $signed({seg_x0_i[CW-1], seg_x0_i[CW-1:0]});
      d0y_q <= $signed({seg_y1_i[CW-1], seg_y1_i[CW-1:0]})
             - $signed({seg_y0_i[CW-1], seg_y0_i[CW-1:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= soc_pkg::ST_IDLE;
      eps_q       <= soc_pkg::EPS_RESET;
      count_q     <= '0;
      step_q      <= '0;
      drain_q     <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      out_cnt_q   <= '0;
      status_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (det_epsilon_we_i) begin
        eps_q <= det_epsilon_i;
      end
      if ((accept && (req_type_i != soc_pkg::REQ_QUERY)) || load_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        step_q  <= '0;
        drain_q <= '0;
        found_q <= 1'b0;
        found_idx_q <= '0;
        if (req_type_i != soc_pkg::REQ_QUERY) begin
          hit_q       <= 1'b0;
          idx_q       <= '0;
          status_q    <= (req_type_i == soc_pkg::REQ_APPEND) && full;
          if (req_type_i == soc_pkg::REQ_CLEAR) begin
            count_q   <= '0;
            out_cnt_q <= '0;
          end else if (do_append) begin
            count_q   <= count_q + 1'b1;
            out_cnt_q <= count_q + 1'b1;
          end else begin
            out_cnt_q <= count_q;
          end
        end
      end
      if (state_q == soc_pkg::ST_RUN && !step_last) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == soc_pkg::ST_DRAIN) begin
        drain_q <= drain_q + 1'b1;
      end
      if (res.valid && !found_q) begin
        found_q     <= 1'b1;
        found_idx_q <= res.idx;
      end
      if (load_done) begin
        hit_q       <= found_q;
        idx_q       <= found_idx_q;
        out_cnt_q   <= count_q;
        status_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign hit_index_o      = soc_pkg::OUT_IDX_W'(idx_q);
  assign obstacle_count_o = soc_pkg::OUT_CNT_W'(out_cnt_q);
  assign status_o         = status_q;

endmodule

>>> design/soc_checker.sv
// Port-level assertions for the segment collision checker, bound to the top level.
module soc_checker #(
  parameter int unsigned MAX_OBSTACLES = soc_pkg::MAX_OBSTACLES_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          hit_o,
  input logic [soc_pkg::OUT_IDX_W-1:0] hit_index_o,
  input logic [soc_pkg::OUT_CNT_W-1:0] obstacle_count_o,
  input logic                          status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result word dropped before it was taken.");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !hit_o &&
      (32'(obstacle_count_o) == 32'(MAX_OBSTACLES)))
    else $error("Refused append while the table was not full.");

  a_no_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_index_o == '0)
    else $error("Index reported without a hit.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(obstacle_count_o) <= 32'(MAX_OBSTACLES))
    else $error("Obstacle count beyond table size.");

endmodule

bind segment_obstacle_collision_check soc_checker #(.MAX_OBSTACLES(MAX_OBSTACLES)) u_soc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .hit_o            (hit_o),
  .hit_index_o      (hit_index_o),
  .obstacle_count_o (obstacle_count_o),
  .status_o         (status_o)
);

>>> bench/segment_obstacle_collision_check_tb.sv
// Self-checking testbench for the segment obstacle collision checker.
module segment_obstacle_collision_check_tb;

  localparam logic [soc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned TABLE_DEPTH = soc_pkg::MAX_OBSTACLES_DEF;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_WORDS = 1950;

  typedef struct {
    logic [soc_pkg::REQ_W-1:0] req;
    logic signed [15:0] x0, y0, x1, y1;
  } seg_word_t;

  typedef struct {
    logic hit;
    logic [soc_pkg::OUT_IDX_W-1:0] idx;
    logic [soc_pkg::OUT_CNT_W-1:0] count;
    logic status;
  } verdict_t;

  typedef struct {
    seg_word_t word;
    bit known;
    verdict_t verdict;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic det_epsilon_we_i = 1'b0;
  logic [soc_pkg::EPS_W-1:0] det_epsilon_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [soc_pkg::REQ_W-1:0] req_type_i = '0;
  logic [15:0] seg_x0_i = '0, seg_y0_i = '0, seg_x1_i = '0, seg_y1_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic [soc_pkg::OUT_IDX_W-1:0] hit_index_o;
  logic [soc_pkg::OUT_CNT_W-1:0] obstacle_count_o;
  logic status_o;

  seg_word_t obstacles [TABLE_DEPTH];
  int unsigned stored = 0;
  logic [soc_pkg::EPS_W-1:0] epsilon = soc_pkg::EPS_RESET;
  verdict_t pending [$];
  int unsigned failures = 0;
  int unsigned words_taken = 0;
  int unsigned idle_cycles = 0;

  segment_obstacle_collision_check dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic bit in_unit(longint num, longint det);
    if (det > 0) begin
      return num >= 0 && num <= det;
    end
    return num <= 0 && num >= det;
  endfunction

  function automatic bit segments_cross(seg_word_t p, seg_word_t q);
    longint d0x, d0y, d1x, d1y, rx, ry, det, mag;
    d0x = longint'(p.x1) - p.x0;
    d0y = longint'(p.y1) - p.y0;
    d1x = longint'(q.x1) - q.x0;
    d1y = longint'(q.y1) - q.y0;
    rx = longint'(q.x0) - p.x0;
    ry = longint'(q.y0) - p.y0;
    det = d0x * d1y - d0y * d1x;
    mag = det < 0 ? -det : det;
    if (mag <= longint'(epsilon)) begin
      return 1'b0;
    end
    return in_unit(rx * d1y - ry * d1x, det) && in_unit(rx * d0y - ry * d0x, det);
  endfunction

  function automatic verdict_t apply_word(seg_word_t w);
    verdict_t v;
    v = '{hit: 1'b0, idx: '0, count: '0, status: 1'b0};
    case (w.req)
      soc_pkg::REQ_CLEAR: begin
        stored = 0;
      end
      soc_pkg::REQ_APPEND: begin
        if (stored >= TABLE_DEPTH) begin
          v.status = 1'b1;
        end else begin
          obstacles[stored] = w;
          stored++;
        end
      end
      soc_pkg::REQ_QUERY: begin
        for (int i = 0; i < stored; i++) begin
          if (segments_cross(w, obstacles[i])) begin
            v.hit = 1'b1;
            v.idx = i[soc_pkg::OUT_IDX_W-1:0];
            break;
          end
        end
      end
      default: ;
    endcase
    v.count = stored[soc_pkg::OUT_CNT_W-1:0];
    return v;
  endfunction

  task automatic send_word(seg_word_t w, bit known, verdict_t typed);
    int gap;
    verdict_t v;
    in_valid_i <= 1'b1;
    req_type_i <= w.req;
    seg_x0_i <= w.x0;
    seg_y0_i <= w.y0;
    seg_x1_i <= w.x1;
    seg_y1_i <= w.y1;
    do @(posedge clk_i); while (!in_ready_o);
    v = apply_word(w);
    if (known) begin
      pending.insert(pending.size(), typed);
    end else begin
      pending.insert(pending.size(), v);
    end
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) begin
      gap = 0;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_epsilon(logic [soc_pkg::EPS_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    det_epsilon_we_i <= 1'b1;
    det_epsilon_i <= value;
    @(posedge clk_i);
    det_epsilon_we_i <= 1'b0;
    epsilon = value;
  endtask

  function automatic seg_word_t random_word();
    seg_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      w.req = soc_pkg::REQ_CLEAR;
    end else if (pick < 5) begin
      w.req = REQ_UNUSED;
    end else if (pick < 52) begin
      w.req = soc_pkg::REQ_APPEND;
    end else begin
      w.req = soc_pkg::REQ_QUERY;
    end
    w.x0 = 16'($urandom());
    w.y0 = 16'($urandom());
    w.x1 = 16'($urandom());
    w.y1 = 16'($urandom());
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        want = pending.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit_o));
        check_field("hit_index", 32'(want.idx), 32'(hit_index_o));
        check_field("obstacle_count", 32'(want.count), 32'(obstacle_count_o));
        check_field("status", 32'(want.status), 32'(status_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
      if (in_valid_i && in_ready_o) begin
        words_taken <= words_taken + 1;
      end
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("segment_obstacle_collision_check test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && words_taken >= 200) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if ($urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                             : $urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  initial begin
    plan_row_t plan [10];
    logic [soc_pkg::EPS_W-1:0] eps_steps [5];
    int unsigned per_phase;
    plan = '{
      '{'{soc_pkg::REQ_QUERY, 16'sh0000, 16'sh0000, 16'sh2000, 16'sh2000}, 1'b1,
        '{1'b0, 6'd0, 7'd0, 1'b0}},
      '{'{REQ_UNUSED, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b1,
        '{1'b0, 6'd0, 7'd0, 1'b0}},
      '{'{soc_pkg::REQ_APPEND, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF}, 1'b1,
        '{1'b0, 6'd0, 7'd1, 1'b0}},
      '{'{soc_pkg::REQ_QUERY, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000}, 1'b0,
        '{1'b0, 6'd0, 7'd0, 1'b0}},
      '{'{soc_pkg::REQ_QUERY, 16'sh8000, 16'sh8001, 16'sh7FFF, 16'sh7FFF}, 1'b0,
        '{1'b0, 6'd0, 7'd0, 1'b0}},
      '{'{soc_pkg::REQ_QUERY, 16'sh0000, 16'sh0000, 16'sh1000, 16'sh1000}, 1'b0,
        '{1'b0, 6'd0, 7'd0, 1'b0}},
      '{'{soc_pkg::REQ_APPEND, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b1,
        '{1'b0, 6'd0, 7'd2, 1'b0}},
      '{'{soc_pkg::REQ_QUERY, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh7FFF}, 1'b0,
        '{1'b0, 6'd0, 7'd0, 1'b0}},
      '{'{soc_pkg::REQ_CLEAR, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b1,
        '{1'b0, 6'd0, 7'd0, 1'b0}},
      '{'{soc_pkg::REQ_QUERY, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000}, 1'b1,
        '{1'b0, 6'd0, 7'd0, 1'b0}}
    };
    eps_steps = '{30'd0, 30'h3FFFFFFF, soc_pkg::EPS_RESET, 30'd0, 30'd0};
    eps_steps[3] = soc_pkg::EPS_W'($urandom_range(0, 1 << 24));
    eps_steps[4] = soc_pkg::EPS_W'($urandom());
    per_phase = RANDOM_WORDS / 6;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) begin
      send_word(plan[i].word, plan[i].known, plan[i].verdict);
    end
    repeat (per_phase) send_word(random_word(), 1'b0, plan[0].verdict);
    foreach (eps_steps[i]) begin
      write_epsilon(eps_steps[i]);
      repeat (per_phase) send_word(random_word(), 1'b0, plan[0].verdict);
    end
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (failures == 0) begin
      $display("segment_obstacle_collision_check test passed");
    end else begin
      $display("segment_obstacle_collision_check test failed");
    end
    $finish;
  end

endmodule
